>>> src/mfde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and command codes for the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_READ   = 3'd2,
		CMD_LINE   = 3'd3,
		CMD_FILL   = 3'd4,
		CMD_CIRCLE = 3'd5
	} cmd_code_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [11:0] x_pos;
		logic signed [11:0] y_pos;
		logic signed [11:0] x_end;
		logic signed [11:0] y_end;
		logic signed [11:0] width;
		logic signed [11:0] height;
		logic [10:0]        radius;
		logic               ink;
	} cmd_item_t;

	typedef struct packed {
		logic       pixel_value;
		logic [2:0] done_cmd;
	} result_item_t;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;
	localparam logic [7:0] MASK_LEFT  = 8'h80;

endpackage

>>> src/mfde_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/mono_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Sequenced draw engine over a 1-bit-per-pixel byte framebuffer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Busy then stays high
// until the single result strobe, and the receiver cannot stall that strobe.
// Every pixel touched costs one read-modify-write of the frame RAM, passing
// the address, read, write and step states (a read command skips the write).
// After reset the frame RAM is swept to zero while busy is held high.
module mono_framebuffer_draw_engine
	import mfde_pkg::*;
#(
	parameter int CANVAS_WIDTH  = 128,
	parameter int CANVAS_HEIGHT = 64,
	parameter int STORE_BYTES   = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  cmd_item_t    cmd_in,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	output logic         result_valid,
	output result_item_t result
);

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CW = 14;

	typedef enum logic [9:0] {
		ST_INIT   = 10'b0000000001,
		ST_IDLE   = 10'b0000000010,
		ST_CLEAR  = 10'b0000000100,
		ST_PIX    = 10'b0000001000,
		ST_RD     = 10'b0000010000,
		ST_WR     = 10'b0000100000,
		ST_NEXT   = 10'b0001000000,
		ST_CPT    = 10'b0010000000,
		ST_CSTEP  = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [2:0] cmd_q;
	logic color_q, ink_q, pv_q;
	logic signed [CW-1:0] x_q, y_q, x1_q, y1_q, dx_q, dy_q, err_q;
	logic signed [CW-1:0] xs_q, xe_q, ye_q, cx_q, cy_q, px_q, py_q;
	logic sx_q, sy_q;
	logic [2:0] oct_q;
	logic [AW:0] clr_q;
	logic [AW-1:0] addr_q;
	logic [2:0] bit_q;
	logic hit_q;

	// Pixel location (one add/compare path).
	logic signed [CW-1:0] px_x, px_y;
	logic on_canvas;
	logic [31:0] lin_addr;
	always_comb begin
		px_x = x_q;
		px_y = y_q;
		if (cmd_q == CMD_CIRCLE) begin
			case (oct_q)
				3'd0: begin px_x = cx_q + px_q; px_y = cy_q + py_q; end
				3'd1: begin px_x = cx_q + py_q; px_y = cy_q + px_q; end
				3'd2: begin px_x = cx_q - py_q; px_y = cy_q + px_q; end
				3'd3: begin px_x = cx_q - px_q; px_y = cy_q + py_q; end
				3'd4: begin px_x = cx_q - px_q; px_y = cy_q - py_q; end
				3'd5: begin px_x = cx_q - py_q; px_y = cy_q - px_q; end
				3'd6: begin px_x = cx_q + py_q; px_y = cy_q - px_q; end
				default: begin px_x = cx_q + px_q; px_y = cy_q - py_q; end
			endcase
		end
		lin_addr = 32'(px_y) * 32'(CANVAS_WIDTH / 8) + 32'(px_x >>> 3);
		on_canvas = (px_x >= 0) && (px_y >= 0) && (px_x < CW'(CANVAS_WIDTH))
			&& (px_y < CW'(CANVAS_HEIGHT)) && (lin_addr < 32'(STORE_BYTES));
	end

	// RAM port.
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata, bmask;
	assign bmask = MASK_LEFT >> bit_q;
	always_comb begin
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = BYTE_ZEROS;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_addr = clr_q[AW-1:0];
			ram_wdata = (state_q == ST_CLEAR && ink_q) ? BYTE_ONES : BYTE_ZEROS;
		end else if (state_q == ST_WR && hit_q && cmd_q != CMD_READ) begin
			ram_we = 1'b1;
			ram_wdata = ((cmd_q == CMD_WRITE) ? ink_q : color_q)
				? (ram_rdata | bmask) : (ram_rdata & ~bmask);
		end
	end

	mfde_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Bresenham decisions.
	logic signed [CW+1:0] e2;
	logic line_end, step_x, step_y;
	assign e2 = (CW+2)'(err_q) <<< 1;
	assign line_end = (x_q == x1_q) && (y_q == y1_q);
	assign step_x = e2 >= (CW+2)'(dy_q);
	assign step_y = e2 <= (CW+2)'(dx_q);

	logic signed [CW-1:0] cin_x, cin_y, cin_w, cin_h;
	assign cin_x = CW'(cmd_in.x_pos);
	assign cin_y = CW'(cmd_in.y_pos);
	assign cin_w = CW'(cmd_in.width);
	assign cin_h = CW'(cmd_in.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			color_q <= 1'b1;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(STORE_BYTES - 1)) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd_in.cmd;
						ink_q <= cmd_in.ink;
						pv_q <= 1'b0;
						oct_q <= '0;
						case (cmd_in.cmd)
							CMD_CLEAR: begin
								clr_q <= '0;
								state_q <= ST_CLEAR;
							end
							CMD_WRITE, CMD_READ: begin
								x_q <= cin_x;
								y_q <= cin_y;
								state_q <= ST_PIX;
							end
							CMD_LINE: begin
								x_q <= cin_x;
								y_q <= cin_y;
								x1_q <= CW'(cmd_in.x_end);
								y1_q <= CW'(cmd_in.y_end);
								dx_q <= (cmd_in.x_end > cmd_in.x_pos)
									? CW'(cmd_in.x_end) - cin_x : cin_x - CW'(cmd_in.x_end);
								dy_q <= (cmd_in.y_end > cmd_in.y_pos)
									? cin_y - CW'(cmd_in.y_end) : CW'(cmd_in.y_end) - cin_y;
								sx_q <= cmd_in.x_pos < cmd_in.x_end;
								sy_q <= cmd_in.y_pos < cmd_in.y_end;
								state_q <= ST_CSTEP;
							end
							CMD_FILL: begin
								if (cmd_in.width <= 0 || cmd_in.height <= 0) begin
									state_q <= ST_DONE;
								end else begin
									x_q <= (cin_x < 0) ? '0 : cin_x;
									y_q <= (cin_y < 0) ? '0 : cin_y;
									xs_q <= (cin_x < 0) ? '0 : cin_x;
									xe_q <= (cin_x + cin_w > CW'(CANVAS_WIDTH))
										? CW'(CANVAS_WIDTH) : cin_x + cin_w;
									ye_q <= (cin_y + cin_h > CW'(CANVAS_HEIGHT))
										? CW'(CANVAS_HEIGHT) : cin_y + cin_h;
									state_q <= ST_NEXT;
								end
							end
							CMD_CIRCLE: begin
								cx_q <= cin_x;
								cy_q <= cin_y;
								px_q <= CW'(cmd_in.radius);
								py_q <= '0;
								err_q <= CW'(1) - CW'(cmd_in.radius);
								state_q <= ST_CPT;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CSTEP: begin
					if (cmd_q == CMD_CIRCLE) begin
						// The circle steps once all eight octant pixels are done.
						py_q <= py_q + CW'(1);
						if (err_q < 0) begin
							err_q <= err_q + ((py_q + CW'(1)) <<< 1) + CW'(1);
						end else begin
							px_q <= px_q - CW'(1);
							err_q <= err_q + ((py_q + CW'(1) - (px_q - CW'(1))) <<< 1)
								+ CW'(1);
						end
						state_q <= ST_CPT;
					end else begin
						// Line setup finishes here: err = dx + dy.
						err_q <= dx_q + dy_q;
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					hit_q <= on_canvas;
					addr_q <= lin_addr[AW-1:0];
					bit_q <= px_x[2:0];
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (cmd_q == CMD_READ) begin
						pv_q <= hit_q && ((ram_rdata & bmask) != BYTE_ZEROS);
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					case (cmd_q)
						CMD_LINE: begin
							if (line_end) begin
								state_q <= ST_DONE;
							end else begin
								if (step_x) x_q <= sx_q ? x_q + CW'(1) : x_q - CW'(1);
								if (step_y) y_q <= sy_q ? y_q + CW'(1) : y_q - CW'(1);
								err_q <= err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
								state_q <= ST_PIX;
							end
						end
						CMD_FILL: begin
							// Entered first from IDLE with the start pixel in x_q/y_q.
							if (y_q >= ye_q || xs_q >= xe_q) begin
								state_q <= ST_DONE;
							end else if (x_q >= xe_q) begin
								x_q <= xs_q;
								y_q <= y_q + CW'(1);
							end else begin
								state_q <= ST_PIX;
								cmd_q <= CMD_FILL;
							end
						end
						CMD_CIRCLE: begin
							oct_q <= oct_q + 1'b1;
							state_q <= (oct_q == 3'd7) ? ST_CSTEP : ST_PIX;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_CPT: begin
					state_q <= (px_q >= py_q) ? ST_PIX : ST_DONE;
				end
				ST_DONE: begin
					result_valid <= 1'b1;
					result.pixel_value <= pv_q;
					result.done_cmd <= cmd_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_INIT;
			endcase
			// Fill advances x after each written pixel.
			if (state_q == ST_WR && cmd_q == CMD_FILL) begin
				x_q <= x_q + CW'(1);
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after transfer");
	a_done_echo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.pixel_value || result.done_cmd == CMD_READ))
		else $error("pixel value set on non-read command");
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");
`endif

endmodule
